// ----- hw/rtl/cfr_pkg.sv -----
// ----------------------------------------------------------------------------
// cfr_pkg: shared definitions for the CRC-checked command frame receiver
// Command codes, acknowledge bytes, CRC-16/XMODEM constants and the
// one-byte CRC update function.
// ----------------------------------------------------------------------------
package cfr_pkg;

    // Default frame length: payload bytes plus a two-byte CRC trailer.
    localparam int FRAME_LENGTH_DEF = 6;

    // CRC-16/XMODEM constants.
    localparam logic [15:0] CRC_POLY         = 16'h1021;
    localparam logic [15:0] EXPECTED_CRC_RST = 16'h93E1;

    // Acknowledge sequence sent for an accepted frame.
    localparam logic [7:0] ACK_BYTE_0 = 8'hF1;
    localparam logic [7:0] ACK_BYTE_1 = 8'h55;
    localparam logic [7:0] ACK_BYTE_2 = 8'hAA;
    localparam logic [7:0] ACK_BYTE_3 = 8'hF4;

    // Input command codes. The fourth code is unused and ignored.
    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_IDLE  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    // Position of a beat inside the four-beat acknowledge burst.
    typedef logic [1:0] t_beat;

    // Acknowledge byte for a given burst position.
    function automatic logic [7:0] ack_byte(input t_beat beat);
        logic [7:0] b;
        case (beat)
            2'd0:    b = ACK_BYTE_0;
            2'd1:    b = ACK_BYTE_1;
            2'd2:    b = ACK_BYTE_2;
            default: b = ACK_BYTE_3;
        endcase
        return b;
    endfunction

    // One byte of CRC-16/XMODEM, MSB first, unrolled over eight bit steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/cfr_if.sv -----
// ----------------------------------------------------------------------------
// cfr_if: valid/ready channels of the command frame receiver
// Input channel (commands and bytes), acknowledge output channel and the
// expected-CRC configuration write channel.
// ----------------------------------------------------------------------------

// Received bytes and line events.
interface cfr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

// Acknowledge beats.
interface cfr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tx_byte;
    logic        last;
    logic [31:0] frame_bytes;
    logic        pending;

    modport source (output valid, output tx_byte, output last, output frame_bytes,
                    output pending, input ready);
    modport sink   (input valid, input tx_byte, input last, input frame_bytes,
                    input pending, output ready);
endinterface

// Expected CRC register write.
interface cfr_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] expected_crc;

    modport source (output valid, output expected_crc, input ready);
    modport sink   (input valid, input expected_crc, output ready);
endinterface

// ----- hw/rtl/crc_checked_command_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// crc_checked_command_frame_receiver_core: command frame receiver with CRC check
// Counts received bytes, runs CRC-16/XMODEM over the payload, checks frames on
// line idle and emits a four-beat acknowledge for each accepted frame.
// ----------------------------------------------------------------------------
// The receiver takes one input beat per clock. A received byte, a line-idle
// event or a clear command is fully processed in the cycle it is accepted: the
// CRC update is an unrolled eight-step shift over one byte. An accepted frame
// queues a four-beat acknowledge burst (F1 55 AA F4, last on the fourth beat)
// carrying the latched payload; each beat leaves when the sink is
// ready. One burst can be in flight and one more can wait behind it, so input
// beats keep flowing while an acknowledge drains; the input stalls only when a
// second burst is already waiting. The configuration channel is always ready.
module crc_checked_command_frame_receiver_core #(
    parameter int FRAME_LENGTH = cfr_pkg::FRAME_LENGTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cfr_in_if.sink    i_in,
    cfr_out_if.source o_out,
    cfr_cfg_if.sink   i_cfg
);

    localparam int PAYLOAD_LEN = FRAME_LENGTH - 2;
    localparam logic [2:0] PAYLOAD_LEN_C = 3'(PAYLOAD_LEN);
    localparam logic [2:0] FRAME_LEN_C   = 3'(FRAME_LENGTH);
    localparam logic [2:0] COUNT_MAX     = 3'(FRAME_LENGTH + 1);
    localparam logic [31:0] LATCH_MASK   = (PAYLOAD_LEN >= 4) ? 32'hFFFF_FFFF :
        32'((64'd1 << (8 * PAYLOAD_LEN)) - 64'd1);

    // Receive state.
    logic [2:0]  r_byte_count, n_byte_count;
    logic [15:0] r_crc,        n_crc;
    logic [31:0] r_payload,    n_payload;
    logic [15:0] r_trailer,    n_trailer;
    logic        r_pending,    n_pending;
    logic [31:0] r_latched,    n_latched;
    logic [15:0] r_expected;

    // Acknowledge burst state: the burst on the port and one waiting burst.
    logic            r_out_valid, n_out_valid;
    cfr_pkg::t_beat  r_beat,      n_beat;
    logic [31:0]     r_cur_data,  n_cur_data;
    logic            r_nxt_valid, n_nxt_valid;
    logic [31:0]     r_nxt_data,  n_nxt_data;

    logic in_fire;
    logic new_burst;
    logic frame_ok;
    logic out_fire;
    logic burst_done;
    logic cur_free;

    assign i_in.ready  = !r_nxt_valid;
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_in.valid && i_in.ready;

    // Frame check on a line-idle event.
    assign frame_ok = !r_pending && (r_byte_count == FRAME_LEN_C) &&
                      (r_crc == r_expected) && (r_trailer == r_expected);

    // Receive path: byte capture, CRC, frame acceptance and clear.
    always_comb begin
        n_byte_count = r_byte_count;
        n_crc        = r_crc;
        n_payload    = r_payload;
        n_trailer    = r_trailer;
        n_pending    = r_pending;
        n_latched    = r_latched;
        new_burst    = 1'b0;
        if (in_fire) begin
            case (cfr_pkg::t_cmd'(i_in.cmd))
                cfr_pkg::CMD_BYTE: begin
                    if (r_byte_count < PAYLOAD_LEN_C) begin
                        n_payload[8 * r_byte_count[1:0] +: 8] = i_in.rx_byte;
                        n_crc = cfr_pkg::crc_byte(r_crc, i_in.rx_byte);
                    end else if (r_byte_count < FRAME_LEN_C) begin
                        n_trailer = {r_trailer[7:0], i_in.rx_byte};
                    end
                    if (r_byte_count < COUNT_MAX) begin
                        n_byte_count = r_byte_count + 3'd1;
                    end
                end
                cfr_pkg::CMD_IDLE: begin
                    n_byte_count = '0;
                    n_crc        = '0;
                    if (frame_ok) begin
                        n_latched = (r_latched & ~LATCH_MASK) | (r_payload & LATCH_MASK);
                        n_pending = 1'b1;
                        new_burst = 1'b1;
                    end
                end
                cfr_pkg::CMD_CLEAR: begin
                    n_pending = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Acknowledge sequencing: advance beats, promote the waiting burst.
    assign out_fire   = r_out_valid && o_out.ready;
    assign burst_done = out_fire && (r_beat == 2'd3);
    assign cur_free   = !r_out_valid || burst_done;

    always_comb begin
        n_out_valid = r_out_valid;
        n_beat      = r_beat;
        n_cur_data  = r_cur_data;
        n_nxt_valid = r_nxt_valid;
        n_nxt_data  = r_nxt_data;
        if (out_fire && (r_beat != 2'd3)) begin
            n_beat = r_beat + 2'd1;
        end
        if (cur_free) begin
            if (r_nxt_valid) begin
                n_out_valid = 1'b1;
                n_beat      = '0;
                n_cur_data  = r_nxt_data;
                n_nxt_valid = 1'b0;
            end else if (new_burst) begin
                n_out_valid = 1'b1;
                n_beat      = '0;
                n_cur_data  = n_latched;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (new_burst) begin
            n_nxt_valid = 1'b1;
            n_nxt_data  = n_latched;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_crc        <= '0;
            r_payload    <= '0;
            r_trailer    <= '0;
            r_pending    <= 1'b0;
            r_latched    <= '0;
            r_expected   <= cfr_pkg::EXPECTED_CRC_RST;
            r_out_valid  <= 1'b0;
            r_beat       <= '0;
            r_nxt_valid  <= 1'b0;
        end else begin
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
            r_payload    <= n_payload;
            r_trailer    <= n_trailer;
            r_pending    <= n_pending;
            r_latched    <= n_latched;
            r_out_valid  <= n_out_valid;
            r_beat       <= n_beat;
            r_nxt_valid  <= n_nxt_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_expected <= i_cfg.expected_crc;
            end
        end
    end

    // Burst payload registers.
    always_ff @(posedge i_clk) begin
        r_cur_data <= n_cur_data;
        r_nxt_data <= n_nxt_data;
    end

    // Output beat.
    assign o_out.valid       = r_out_valid;
    assign o_out.tx_byte     = cfr_pkg::ack_byte(r_beat);
    assign o_out.last        = (r_beat == 2'd3);
    assign o_out.frame_bytes = r_cur_data;
    assign o_out.pending     = 1'b1;

endmodule

// ----- hw/rtl/cfr_checker.sv -----
// ----------------------------------------------------------------------------
// cfr_checker: port-level assertions for the command frame receiver
// Checks the acknowledge burst order and the output handshake, and is bound
// to the receiver core.
// ----------------------------------------------------------------------------
module cfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_tx_byte,
    input logic        i_last,
    input logic [31:0] i_frame_bytes,
    input logic        i_pending
);

    // A stalled beat stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_tx_byte) &&
        $stable(i_last) && $stable(i_frame_bytes))
        else $error("acknowledge beat changed while stalled");

    // The last marker belongs to the final acknowledge byte only.
    a_last_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last == (i_tx_byte == cfr_pkg::ACK_BYTE_3)))
        else $error("last marker not on final acknowledge byte");

    // Once the first beat of a burst is taken, the second byte follows at once.
    a_burst_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_tx_byte == cfr_pkg::ACK_BYTE_0 |=>
        i_out_valid && i_tx_byte == cfr_pkg::ACK_BYTE_1)
        else $error("acknowledge burst out of order");

    // The latched payload holds across a burst.
    a_burst_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last |=> $stable(i_frame_bytes))
        else $error("payload changed inside a burst");

    // Every acknowledge reports the pending flag set.
    a_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_pending)
        else $error("acknowledge without pending flag");

endmodule

bind crc_checked_command_frame_receiver_core cfr_checker u_cfr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_tx_byte    (o_out.tx_byte),
    .i_last       (o_out.last),
    .i_frame_bytes(o_out.frame_bytes),
    .i_pending    (o_out.pending)
);

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the command frame receiver core
// Feeds received bytes, line-idle events and clear commands, predicts the
// four-beat acknowledge for every accepted frame and checks each output beat.
// ----------------------------------------------------------------------------
// A directed run comes first. It sends a good frame, another good frame while
// a command is pending, an unused command, a clear, an overlong frame and a
// short frame built from the extreme byte values. Three random phases follow,
// each under a different expected CRC and a different pattern of source and
// sink stalls. Good frames are built so that both the running CRC and the
// trailer hit the configured value. The last phase also holds the sink off
// for a long stretch so that the acknowledge buffering fills and the input
// stalls.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_LEN     = cfr_pkg::FRAME_LENGTH_DEF;
    localparam int PAYLOAD_LEN   = FRAME_LEN - 2;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 150;

    // The fourth command code, which the block ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
    } t_rx_beat;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        last;
        logic [31:0] frame_bytes;
        logic        pending;
    } t_ack_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cfr_in_if  rx_ch ();
    cfr_out_if ack_ch ();
    cfr_cfg_if crc_cfg_ch ();

    crc_checked_command_frame_receiver_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (rx_ch),
        .o_out   (ack_ch),
        .i_cfg   (crc_cfg_ch)
    );

    // Beats waiting to be sent and acknowledge beats still to come.
    t_rx_beat  rx_beat_q[$];
    t_ack_beat ack_q[$];

    // Stall settings, in percent of cycles.
    int unsigned src_idle_pct  = 25;
    int unsigned sink_idle_pct = 80;

    // Long sink hold-off: the stimulus bumps hold_reqs, the sink process
    // notices and counts the stretch down itself.
    int unsigned hold_reqs = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    int unsigned beats_built = 0;
    int unsigned beats_taken = 0;
    int unsigned errors      = 0;
    int unsigned cycle_cnt   = 0;

    // Receiver state as the bench predicts it.
    logic [15:0] crc_expect    = cfr_pkg::EXPECTED_CRC_RST;
    int unsigned rx_count      = 0;
    logic [15:0] rx_crc        = '0;
    logic [31:0] payload_buf   = '0;
    logic [15:0] trailer_buf   = '0;
    logic        cmd_pending   = 1'b0;
    logic [31:0] latched_frame = '0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // One byte of CRC-16/XMODEM, most significant bit first.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ cfr_pkg::CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // Undo sixteen zero-input shift steps. Bit 0 of a shifted value tells
    // whether the polynomial was folded in, since the polynomial is odd.
    function automatic logic [15:0] crc16_unshift(input logic [15:0] v);
        logic [15:0] c;
        c = v;
        for (int k = 0; k < 16; k++) begin
            c = c[0] ? (((c ^ cfr_pkg::CRC_POLY) >> 1) | 16'h8000) : (c >> 1);
        end
        return c;
    endfunction

    // Update the predicted state for one accepted input beat.
    task automatic receive_beat(input logic [1:0] cmd, input logic [7:0] data);
        if (cmd == cfr_pkg::CMD_BYTE) begin
            if (rx_count < PAYLOAD_LEN) begin
                payload_buf[8*rx_count +: 8] = data;
                rx_crc = crc16_step(rx_crc, data);
            end else if (rx_count < FRAME_LEN) begin
                trailer_buf = {trailer_buf[7:0], data};
            end
            if (rx_count < FRAME_LEN + 1) begin
                rx_count++;
            end
        end else if (cmd == cfr_pkg::CMD_IDLE) begin
            if (!cmd_pending && rx_count == FRAME_LEN &&
                rx_crc == crc_expect && trailer_buf == crc_expect) begin
                latched_frame = payload_buf;
                cmd_pending   = 1'b1;
                ack_q.push_back('{cfr_pkg::ACK_BYTE_0, 1'b0, latched_frame, 1'b1});
                ack_q.push_back('{cfr_pkg::ACK_BYTE_1, 1'b0, latched_frame, 1'b1});
                ack_q.push_back('{cfr_pkg::ACK_BYTE_2, 1'b0, latched_frame, 1'b1});
                ack_q.push_back('{cfr_pkg::ACK_BYTE_3, 1'b1, latched_frame, 1'b1});
            end
            rx_count = 0;
            rx_crc   = '0;
        end else if (cmd == cfr_pkg::CMD_CLEAR) begin
            cmd_pending = 1'b0;
        end
    endtask

    // Compare one accepted acknowledge beat with the oldest expectation.
    task automatic check_ack_beat();
        t_ack_beat want;
        if (ack_q.size() == 0) begin
            $display("%0t: unexpected ack beat: expected none, ", $time,
                     "got byte %02h last %0b frame %08h pending %0b",
                     ack_ch.tx_byte, ack_ch.last, ack_ch.frame_bytes, ack_ch.pending);
            errors++;
        end else begin
            want = ack_q.pop_front();
            if (ack_ch.tx_byte !== want.tx_byte || ack_ch.last !== want.last ||
                ack_ch.frame_bytes !== want.frame_bytes || ack_ch.pending !== want.pending) begin
                $display("%0t: ack beat mismatch: ", $time,
                         "expected byte %02h last %0b frame %08h pending %0b",
                         want.tx_byte, want.last, want.frame_bytes, want.pending);
                $display("%0t:                    ", $time,
                         "got      byte %02h last %0b frame %08h pending %0b",
                         ack_ch.tx_byte, ack_ch.last, ack_ch.frame_bytes, ack_ch.pending);
                errors++;
            end
        end
    endtask

    task automatic push_beat(input logic [1:0] cmd, input logic [7:0] data);
        rx_beat_q.push_back('{cmd, data});
        beats_built++;
    endtask

    // Queue a six-byte frame whose payload CRC and trailer both equal target,
    // optionally with one byte damaged and with extra bytes before the idle.
    task automatic queue_frame(input logic [15:0] target, input int corrupt_at,
                               input int extra_bytes);
        logic [7:0]  fb[FRAME_LEN];
        logic [15:0] mid;
        logic [15:0] tail;
        fb[0] = 8'($urandom());
        fb[1] = 8'($urandom());
        mid   = crc16_step(crc16_step(16'h0000, fb[0]), fb[1]);
        tail  = crc16_unshift(target) ^ mid;
        fb[2] = tail[15:8];
        fb[3] = tail[7:0];
        fb[4] = target[15:8];
        fb[5] = target[7:0];
        if (corrupt_at >= 0) begin
            fb[corrupt_at] ^= 8'($urandom_range(255, 1));
        end
        for (int i = 0; i < FRAME_LEN; i++) begin
            push_beat(cfr_pkg::CMD_BYTE, fb[i]);
        end
        for (int i = 0; i < extra_bytes; i++) begin
            push_beat(cfr_pkg::CMD_BYTE, 8'($urandom()));
        end
        push_beat(cfr_pkg::CMD_IDLE, 8'($urandom()));
    endtask

    // Mostly good frames with random content, the rest damaged frames,
    // frames of the wrong length, clears and stray commands.
    task automatic queue_random_traffic(input int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned len;
        stop_at = beats_built + count;
        while (beats_built < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                if ($urandom_range(99) < 70) begin
                    push_beat(cfr_pkg::CMD_CLEAR, 8'($urandom()));
                end
                queue_frame(crc_expect, -1, 0);
            end else if (pick < 70) begin
                if ($urandom_range(1) == 1) begin
                    push_beat(cfr_pkg::CMD_CLEAR, 8'($urandom()));
                end
                queue_frame(crc_expect, $urandom_range(FRAME_LEN - 1), 0);
            end else if (pick < 82) begin
                len = $urandom_range(FRAME_LEN + 3);
                if (len == FRAME_LEN) begin
                    len = FRAME_LEN + 1;
                end
                for (int i = 0; i < len; i++) begin
                    push_beat(cfr_pkg::CMD_BYTE, 8'($urandom()));
                end
                push_beat(cfr_pkg::CMD_IDLE, 8'($urandom()));
            end else if (pick < 92) begin
                push_beat(2'($urandom_range(3)), 8'($urandom()));
            end else begin
                push_beat(cfr_pkg::CMD_CLEAR, 8'($urandom()));
            end
        end
    endtask

    // Wait until every queued beat has been accepted and every acknowledge
    // has come, then let the block settle. Both counts move together in the
    // monitor, so the check does not depend on process order at an edge.
    task automatic wait_quiet();
        while (beats_taken != beats_built || ack_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the expected CRC register; called only while the block is quiet.
    task automatic write_expected_crc(input logic [15:0] value);
        crc_cfg_ch.valid        <= 1'b1;
        crc_cfg_ch.expected_crc <= value;
        @(posedge i_clk);
        while (!crc_cfg_ch.ready) begin
            @(posedge i_clk);
        end
        crc_cfg_ch.valid <= 1'b0;
        crc_expect = value;
    endtask

    // Source driver: offers the next queued beat once the current one is taken.
    always @(posedge i_clk) begin
        t_rx_beat nxt;
        if (!i_rst_n) begin
            rx_ch.valid <= 1'b0;
        end else if (!rx_ch.valid || rx_ch.ready) begin
            if (rx_beat_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = rx_beat_q.pop_front();
                rx_ch.valid   <= 1'b1;
                rx_ch.cmd     <= nxt.cmd;
                rx_ch.rx_byte <= nxt.data;
            end else begin
                rx_ch.valid <= 1'b0;
            end
        end
    end

    // Sink ready: random stalls plus the occasional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ack_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            ack_ch.ready <= 1'b0;
        end else if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
            ack_ch.ready <= 1'b0;
        end else begin
            ack_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Monitor: predict on each accepted input beat, then check output beats.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rx_ch.valid && rx_ch.ready) begin
                receive_beat(rx_ch.cmd, rx_ch.rx_byte);
                beats_taken++;
            end
            if (ack_ch.valid && ack_ch.ready) begin
                check_ack_beat();
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_rst_n                 = 1'b0;
        rx_ch.valid             = 1'b0;
        rx_ch.cmd               = cfr_pkg::CMD_BYTE;
        rx_ch.rx_byte           = 8'h00;
        ack_ch.ready            = 1'b0;
        crc_cfg_ch.valid        = 1'b0;
        crc_cfg_ch.expected_crc = cfr_pkg::EXPECTED_CRC_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats under the reset value of the expected CRC.
        queue_frame(crc_expect, -1, 0);
        queue_frame(crc_expect, -1, 0);
        push_beat(CMD_UNUSED, 8'hFF);
        push_beat(cfr_pkg::CMD_CLEAR, 8'h00);
        queue_frame(crc_expect, -1, 1);
        push_beat(cfr_pkg::CMD_BYTE, 8'h00);
        push_beat(cfr_pkg::CMD_BYTE, 8'hFF);
        push_beat(cfr_pkg::CMD_IDLE, 8'h00);
        wait_quiet();

        // Source mostly busy, sink mostly stalled, all-zero CRC.
        write_expected_crc(16'h0000);
        queue_random_traffic(PHASE_ITEMS);
        wait_quiet();

        // Source mostly idle, sink mostly ready, all-ones CRC.
        src_idle_pct  = 80;
        sink_idle_pct = 25;
        write_expected_crc(16'hFFFF);
        queue_random_traffic(PHASE_ITEMS);
        wait_quiet();

        // No idling, random CRC, and a long sink hold-off at the start.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_expected_crc(16'($urandom()));
        hold_reqs++;
        queue_random_traffic(PHASE_ITEMS);
        wait_quiet();

        if (ack_q.size() != 0) begin
            $display("%0t: %0d ack beats expected but never seen", $time, ack_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
